[sv/mrtl_pkg.sv]
// Types and constants shared by the multicast route table lookup block.
// Used by mrtl_ctrl, mrtl_datapath and multicast_route_table_lookup.
`default_nettype none

package mrtl_pkg;

    localparam logic [31:0] BIER_GROUP = 32'hEFFF_FEFE;

    localparam int REQ_W    = 2;
    localparam int GROUP_W  = 32;
    localparam int IF_W     = 8;
    localparam int NODE_W   = 16;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_START  = 2'd1,
        REQ_APPEND = 2'd2,
        REQ_LOOKUP = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 2'd0,
        STS_NO_ROUTE = 2'd1,
        STS_CNT_ERR  = 2'd2,
        STS_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        RES_OK,
        RES_MISS,
        RES_CNT_ERR,
        RES_FULL,
        RES_OUTB,
        RES_FWD_PEND,
        RES_FWD_LAST
    } t_res_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic      load;
        logic      scan_start;
        logic      scan_next;
        logic      list_start;
        logic      list_next;
        logic      pend_load;
        logic      do_clear;
        logic      do_start;
        logic      do_append;
        logic      out_load;
        t_res_kind out_kind;
    } t_dp_cmd;

    typedef struct packed {
        t_req req;
        logic table_full;
        logic no_route;
        logic list_full;
        logic scan_end;
        logic bier;
        logic hit;
        logic outbound;
        logic cnt_one;
        logic list_end;
        logic if_nz;
        logic pend_vld;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

[sv/mrtl_ctrl.sv]
// Controller state machine for the multicast route table lookup block.
// Depends on mrtl_pkg; drives commands to mrtl_datapath from its status.
`default_nettype none

module mrtl_ctrl
    import mrtl_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      s_tvalid,
    output logic     s_tready,
    input  t_dp_sts  i_sts,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_cmd.out_kind = RES_OK;
        s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.req)
                    REQ_CLEAR: begin
                        if (i_sts.out_free) begin
                            o_cmd.do_clear = 1'b1;
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_kind = RES_OK;
                            n_state        = S_IDLE;
                        end
                    end
                    REQ_START: begin
                        if (i_sts.out_free) begin
                            o_cmd.out_load = 1'b1;
                            n_state        = S_IDLE;
                            if (i_sts.table_full) begin
                                o_cmd.out_kind = RES_FULL;
                            end else begin
                                o_cmd.do_start = 1'b1;
                                o_cmd.out_kind = RES_OK;
                            end
                        end
                    end
                    REQ_APPEND: begin
                        if (i_sts.out_free) begin
                            o_cmd.out_load = 1'b1;
                            n_state        = S_IDLE;
                            if (i_sts.no_route) begin
                                o_cmd.out_kind = RES_MISS;
                            end else if (i_sts.list_full) begin
                                o_cmd.out_kind = RES_FULL;
                            end else begin
                                o_cmd.do_append = 1'b1;
                                o_cmd.out_kind  = RES_OK;
                            end
                        end
                    end
                    REQ_LOOKUP: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_sts.scan_end || i_sts.bier) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = RES_MISS;
                        n_state        = S_IDLE;
                    end
                end else if (i_sts.hit) begin
                    if (i_sts.outbound && !i_sts.cnt_one) begin
                        if (i_sts.out_free) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_kind = RES_CNT_ERR;
                            n_state        = S_IDLE;
                        end
                    end else begin
                        o_cmd.list_start = 1'b1;
                        n_state          = S_EMIT;
                    end
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_sts.outbound) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = RES_OUTB;
                        n_state        = S_IDLE;
                    end
                end else if (i_sts.list_end) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = RES_FWD_LAST;
                        n_state        = S_IDLE;
                    end
                end else if (i_sts.if_nz) begin
                    if (!i_sts.pend_vld) begin
                        o_cmd.pend_load = 1'b1;
                        o_cmd.list_next = 1'b1;
                    end else if (i_sts.out_free) begin
                        o_cmd.out_load  = 1'b1;
                        o_cmd.out_kind  = RES_FWD_PEND;
                        o_cmd.pend_load = 1'b1;
                        o_cmd.list_next = 1'b1;
                    end
                end else begin
                    o_cmd.list_next = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/mrtl_datapath.sv]
// Datapath of the multicast route table lookup block: route memories,
// scan and slot counters, pending interface and output register.
// Depends on mrtl_pkg; commanded by mrtl_ctrl.
`default_nettype none

module mrtl_datapath
    import mrtl_pkg::*;
#(
    parameter int MAX_ROUTES  = 16,
    parameter int MAX_OUT_IFS = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire [S_DATA_W-1:0]  i_s_tdata,
    input  wire [REQ_W-1:0]     i_s_tuser,
    input  wire                 i_cfg_we,
    input  wire [NODE_W-1:0]    i_cfg_wdata,
    input  wire                 i_m_tready,
    output logic                o_m_tvalid,
    output logic [M_DATA_W-1:0] o_m_tdata,
    output logic                o_m_tlast,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts
);

    localparam int RCW   = $clog2(MAX_ROUTES + 1);
    localparam int AW    = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int CW    = $clog2(MAX_OUT_IFS + 1);
    localparam int LDEP  = MAX_ROUTES * MAX_OUT_IFS;
    localparam int LW    = (LDEP > 1) ? $clog2(LDEP) : 1;

    logic [GROUP_W-1:0] mem_grp  [MAX_ROUTES];
    logic [CW-1:0]      mem_cnt  [MAX_ROUTES];
    logic [IF_W-1:0]    mem_list [LDEP];

    t_req               r_req;
    logic [GROUP_W-1:0] r_grp;
    logic [IF_W-1:0]    r_oif;
    logic [NODE_W-1:0]  r_src;
    logic [NODE_W-1:0]  r_node_id;

    logic [RCW-1:0]     r_route_count;
    logic [CW-1:0]      r_last_cnt;
    logic [RCW-1:0]     r_idx;
    logic [RCW-1:0]     n_idx;
    logic [CW-1:0]      r_jdx;
    logic [CW-1:0]      n_jdx;

    logic [GROUP_W-1:0] r_grp_q;
    logic [CW-1:0]      r_cnt_q;
    logic [IF_W-1:0]    r_if_q;

    logic               r_pend_vld;
    logic [IF_W-1:0]    r_pend_if;

    logic               r_m_valid;
    logic [STATUS_W-1:0] r_status;
    logic               r_outbound;
    logic               r_has_if;
    logic [IF_W-1:0]    r_out_if;
    logic               r_last;

    logic [RCW-1:0]     w_newest;
    logic [AW-1:0]      w_cnt_wa;
    logic [CW-1:0]      w_cnt_wd;
    logic [LW-1:0]      w_list_wa;
    logic [LW-1:0]      w_list_ra;
    logic               w_out_free;

    assign w_newest  = r_route_count - RCW'(1);
    assign w_cnt_wa  = i_cmd.do_start ? r_route_count[AW-1:0] : w_newest[AW-1:0];
    assign w_cnt_wd  = i_cmd.do_start ? '0 : r_last_cnt + CW'(1);
    assign w_list_wa = LW'(32'(w_newest) * 32'(MAX_OUT_IFS) + 32'(r_last_cnt));
    assign w_list_ra = LW'(32'(r_idx) * 32'(MAX_OUT_IFS) + 32'(n_jdx));
    assign w_out_free = !r_m_valid || i_m_tready;

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.scan_start) begin
            n_idx = '0;
        end else if (i_cmd.scan_next) begin
            n_idx = r_idx + RCW'(1);
        end
        n_jdx = r_jdx;
        if (i_cmd.list_start) begin
            n_jdx = '0;
        end else if (i_cmd.list_next) begin
            n_jdx = r_jdx + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_start) begin
            mem_grp[r_route_count[AW-1:0]] <= r_grp;
        end
        if (i_cmd.do_start || i_cmd.do_append) begin
            mem_cnt[w_cnt_wa] <= w_cnt_wd;
        end
        if (i_cmd.do_append) begin
            mem_list[w_list_wa] <= r_oif;
        end
        r_grp_q <= mem_grp[n_idx[AW-1:0]];
        r_cnt_q <= mem_cnt[n_idx[AW-1:0]];
        r_if_q  <= mem_list[w_list_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= t_req'(i_s_tuser);
            r_grp <= i_s_tdata[31:0];
            r_oif <= i_s_tdata[39:32];
            r_src <= i_s_tdata[55:40];
        end
        r_idx <= n_idx;
        r_jdx <= n_jdx;
        if (i_cmd.pend_load) begin
            r_pend_if <= r_if_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id     <= '0;
            r_route_count <= '0;
            r_last_cnt    <= '0;
            r_pend_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_id <= i_cfg_wdata;
            end
            if (i_cmd.do_clear) begin
                r_route_count <= '0;
            end else if (i_cmd.do_start) begin
                r_route_count <= r_route_count + RCW'(1);
            end
            if (i_cmd.do_start) begin
                r_last_cnt <= '0;
            end else if (i_cmd.do_append) begin
                r_last_cnt <= r_last_cnt + CW'(1);
            end
            if (i_cmd.list_start) begin
                r_pend_vld <= 1'b0;
            end else if (i_cmd.pend_load) begin
                r_pend_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status   <= STS_OK;
            r_outbound <= 1'b0;
            r_has_if   <= 1'b0;
            r_out_if   <= '0;
            r_last     <= 1'b1;
            case (i_cmd.out_kind)
                RES_MISS: begin
                    r_status <= STS_NO_ROUTE;
                end
                RES_CNT_ERR: begin
                    r_status   <= STS_CNT_ERR;
                    r_outbound <= 1'b1;
                end
                RES_FULL: begin
                    r_status <= STS_FULL;
                end
                RES_OUTB: begin
                    r_outbound <= 1'b1;
                    r_has_if   <= 1'b1;
                    r_out_if   <= r_if_q;
                end
                RES_FWD_PEND: begin
                    r_has_if <= 1'b1;
                    r_out_if <= r_pend_if;
                    r_last   <= 1'b0;
                end
                RES_FWD_LAST: begin
                    if (r_pend_vld) begin
                        r_has_if <= 1'b1;
                        r_out_if <= r_pend_if;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {4'b0000, r_out_if, r_has_if, r_outbound, r_status};
    assign o_m_tlast  = r_last;

    always_comb begin
        o_sts            = '0;
        o_sts.req        = r_req;
        o_sts.table_full = (r_route_count >= RCW'(MAX_ROUTES));
        o_sts.no_route   = (r_route_count == '0);
        o_sts.list_full  = (r_last_cnt >= CW'(MAX_OUT_IFS));
        o_sts.scan_end   = (r_idx >= r_route_count);
        o_sts.bier       = (r_grp == BIER_GROUP);
        o_sts.hit        = (r_grp_q == r_grp);
        o_sts.outbound   = (r_src == r_node_id);
        o_sts.cnt_one    = (r_cnt_q == CW'(1));
        o_sts.list_end   = (r_jdx >= r_cnt_q);
        o_sts.if_nz      = (r_if_q != '0);
        o_sts.pend_vld   = r_pend_vld;
        o_sts.out_free   = w_out_free;
    end

endmodule

`default_nettype wire

[sv/multicast_route_table_lookup.sv]
// Clear, start and append each load one result once the output register is free. A lookup
// scans the routes in order and gives one miss result when the scan ends or for BIER_GROUP;
// on a match on route r it walks the slots of route r for its results.
// One transaction at a time, bounded by the route scan and the slot walk; the next
// is accepted in the cycle after the last result loads.
// Reset (synchronous, active low) empties the table and clears node_id; memories keep data.
`default_nettype none

module multicast_route_table_lookup
    import mrtl_pkg::*;
#(
    parameter int MAX_ROUTES  = 16,
    parameter int MAX_OUT_IFS = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 s_tvalid,
    output logic                s_tready,
    // [31:0] group_addr, [39:32] out_if_in, [55:40] source_node
    input  wire [S_DATA_W-1:0]  s_tdata,
    // [1:0] req_type
    input  wire [REQ_W-1:0]     s_tuser,
    output logic                m_tvalid,
    input  wire                 m_tready,
    // [1:0] status, [2] outbound, [3] has_if, [11:4] out_if, [15:12] zero
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    input  wire                 i_cfg_we,
    input  wire [NODE_W-1:0]    i_cfg_wdata
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    mrtl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd)
    );

    mrtl_datapath #(
        .MAX_ROUTES  (MAX_ROUTES),
        .MAX_OUT_IFS (MAX_OUT_IFS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (m_tready),
        .o_m_tvalid  (m_tvalid),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("a second transaction was taken while one is in progress");

    a_no_if_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tdata[3] |-> m_tdata[11:4] == '0)
        else $error("out_if is nonzero without has_if");

    a_outbound_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[2] |-> m_tlast)
        else $error("outbound result is not the last one");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[1:0] != STS_OK |-> m_tlast && !m_tdata[3])
        else $error("error result carries an interface or is not last");

endmodule

`default_nettype wire

[tb/multicast_route_table_lookup_tb.sv]
// Self-checking testbench for multicast_route_table_lookup: a directed table, then random
// clear, start, append and lookup phases under several node_id settings.
// Depends on mrtl_pkg and the multicast_route_table_lookup RTL only.
`default_nettype none

module multicast_route_table_lookup_tb;
    import mrtl_pkg::*;

    localparam int MAX_ROUTES       = 16;
    localparam int MAX_OUT_IFS      = 8;
    localparam int N_DIRECTED       = 23;
    localparam int N_PHASES         = 5;
    localparam int ITEMS_PER_PHASE  = 100;
    localparam int HOLD_CYCLES      = 300;
    localparam int STALL_LIMIT      = 2000;
    localparam int TAIL_CYCLES      = 40;
    localparam int POOL_SIZE        = 6;

    typedef struct packed {
        t_req        req;
        logic [31:0] grp;
        logic [7:0]  oif;
        logic [15:0] src;
        logic        typed;
        t_status     typed_sts;
        logic        typed_outb;
    } t_route_req;

    typedef struct packed {
        t_status    status;
        logic       outbound;
        logic       has_if;
        logic [7:0] out_if;
        logic       last;
    } t_route_result;

    localparam t_route_req DIRECTED [N_DIRECTED] = '{
        '{REQ_APPEND, 32'h0000_0000, 8'h05, 16'h0000, 1'b1, STS_NO_ROUTE, 1'b0},
        '{REQ_LOOKUP, 32'h0000_0000, 8'h00, 16'h0001, 1'b1, STS_NO_ROUTE, 1'b0},
        '{REQ_START,  32'hFFFF_FFFF, 8'h00, 16'h0000, 1'b1, STS_OK,       1'b0},
        '{REQ_APPEND, 32'h0000_0000, 8'hFF, 16'h0000, 1'b1, STS_OK,       1'b0},
        '{REQ_APPEND, 32'h0000_0000, 8'h00, 16'h0000, 1'b1, STS_OK,       1'b0},
        '{REQ_APPEND, 32'h0000_0000, 8'h01, 16'h0000, 1'b1, STS_OK,       1'b0},
        '{REQ_APPEND, 32'h0000_0000, 8'h80, 16'h0000, 1'b1, STS_OK,       1'b0},
        '{REQ_APPEND, 32'h0000_0000, 8'h02, 16'h0000, 1'b1, STS_OK,       1'b0},
        '{REQ_APPEND, 32'h0000_0000, 8'h7F, 16'h0000, 1'b1, STS_OK,       1'b0},
        '{REQ_APPEND, 32'h0000_0000, 8'h00, 16'h0000, 1'b1, STS_OK,       1'b0},
        '{REQ_APPEND, 32'h0000_0000, 8'h55, 16'h0000, 1'b1, STS_OK,       1'b0},
        '{REQ_APPEND, 32'h0000_0000, 8'hAA, 16'h0000, 1'b1, STS_FULL,     1'b0},
        '{REQ_LOOKUP, 32'hFFFF_FFFF, 8'h00, 16'hFFFF, 1'b0, STS_OK,       1'b0},
        '{REQ_LOOKUP, 32'hFFFF_FFFF, 8'h00, 16'h0000, 1'b1, STS_CNT_ERR,  1'b1},
        '{REQ_START,  32'h0000_0000, 8'h00, 16'h0000, 1'b1, STS_OK,       1'b0},
        '{REQ_APPEND, 32'h0000_0000, 8'h00, 16'h0000, 1'b1, STS_OK,       1'b0},
        '{REQ_LOOKUP, 32'h0000_0000, 8'h00, 16'h0000, 1'b0, STS_OK,       1'b0},
        '{REQ_LOOKUP, 32'h0000_0000, 8'h00, 16'h1234, 1'b0, STS_OK,       1'b0},
        '{REQ_START,  BIER_GROUP,    8'h00, 16'h0000, 1'b1, STS_OK,       1'b0},
        '{REQ_LOOKUP, BIER_GROUP,    8'h00, 16'h0005, 1'b1, STS_NO_ROUTE, 1'b0},
        '{REQ_LOOKUP, 32'hA5A5_A5A5, 8'h00, 16'h0000, 1'b1, STS_NO_ROUTE, 1'b0},
        '{REQ_CLEAR,  32'h0000_0000, 8'h00, 16'h0000, 1'b1, STS_OK,       1'b0},
        '{REQ_LOOKUP, 32'hFFFF_FFFF, 8'h00, 16'hFFFF, 1'b1, STS_NO_ROUTE, 1'b0}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [REQ_W-1:0]    s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                i_cfg_we;
    logic [NODE_W-1:0]   i_cfg_wdata;

    t_route_req    cur_req;
    t_route_result route_results_due[$];
    t_route_result predicted[$];
    logic [31:0]   group_pool[POOL_SIZE];

    int          tbl_count = 0;
    logic [31:0] tbl_group[MAX_ROUTES];
    int          tbl_nifs[MAX_ROUTES];
    logic [7:0]  tbl_ifs[MAX_ROUTES][MAX_OUT_IFS];
    logic [15:0] my_node = '0;

    bit calm      = 1'b0;
    bit hold_req  = 1'b0;
    int mismatches = 0;
    int results_seen = 0;
    int requests_sent = 0;
    int lookups_sent = 0;
    int ifs_forwarded = 0;
    int full_refusals = 0;

    multicast_route_table_lookup #(
        .MAX_ROUTES  (MAX_ROUTES),
        .MAX_OUT_IFS (MAX_OUT_IFS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] wanted);
        mismatches++;
        if (mismatches <= 40) begin
            $display("mismatch at %0t: %s got 0x%0h, wanted 0x%0h", $time, what, got, wanted);
        end
    endtask

    function automatic int pick_gap();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (calm || roll < 55) return 0;
        if (roll < 92) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    // Fills predicted with the results one request causes and updates the route table.
    function automatic void predict_route_results(input t_route_req rq);
        t_route_result res;
        t_route_result fwd_res;
        t_route_result fwd[$];
        int r;
        int j;
        int n;
        bit found;
        predicted.delete();
        res = '{STS_OK, 1'b0, 1'b0, 8'h00, 1'b1};
        found = 1'b0;
        case (rq.req)
            REQ_CLEAR: begin
                tbl_count = 0;
            end
            REQ_START: begin
                if (tbl_count >= MAX_ROUTES) begin
                    res.status = STS_FULL;
                end else begin
                    tbl_group[tbl_count] = rq.grp;
                    tbl_nifs[tbl_count] = 0;
                    tbl_count++;
                end
            end
            REQ_APPEND: begin
                if (tbl_count == 0) begin
                    res.status = STS_NO_ROUTE;
                end else if (tbl_nifs[tbl_count-1] >= MAX_OUT_IFS) begin
                    res.status = STS_FULL;
                end else begin
                    tbl_ifs[tbl_count-1][tbl_nifs[tbl_count-1]] = rq.oif;
                    tbl_nifs[tbl_count-1]++;
                end
            end
            default: begin
                res.status = STS_NO_ROUTE;
                if (rq.grp != BIER_GROUP) begin
                    for (r = 0; r < tbl_count && !found; r++) begin
                        if (tbl_group[r] == rq.grp) begin
                            found = 1'b1;
                            n = tbl_nifs[r];
                            if (rq.src == my_node) begin
                                res.outbound = 1'b1;
                                if (n != 1) begin
                                    res.status = STS_CNT_ERR;
                                end else begin
                                    res.status = STS_OK;
                                    res.has_if = 1'b1;
                                    res.out_if = tbl_ifs[r][0];
                                end
                            end else begin
                                res.status = STS_OK;
                                for (j = 0; j < n; j++) begin
                                    if (tbl_ifs[r][j] != 8'h00) begin
                                        fwd_res = '{STS_OK, 1'b0, 1'b1, tbl_ifs[r][j], 1'b0};
                                        fwd.insert(fwd.size(), fwd_res);
                                    end
                                end
                            end
                        end
                    end
                end
            end
        endcase
        if (fwd.size() > 0) begin
            fwd[fwd.size()-1].last = 1'b1;
            predicted = fwd;
        end else begin
            predicted.insert(predicted.size(), res);
        end
    endfunction

    function automatic t_route_req random_request(input int clear_pct, input int start_pct,
                                                  input logic [15:0] node);
        t_route_req rq;
        int roll;
        int oif_roll;
        roll = int'($urandom_range(0, 99));
        oif_roll = int'($urandom_range(0, 99));
        rq.typed = 1'b0;
        rq.typed_sts = STS_OK;
        rq.typed_outb = 1'b0;
        if ($urandom_range(0, 9) == 0) begin
            rq.grp = $urandom;
        end else begin
            rq.grp = group_pool[$urandom_range(0, POOL_SIZE-1)];
        end
        if (oif_roll < 15) begin
            rq.oif = 8'h00;
        end else if (oif_roll < 25) begin
            rq.oif = 8'hFF;
        end else begin
            rq.oif = 8'($urandom);
        end
        rq.src = ($urandom_range(0, 99) < 45) ? node : 16'($urandom);
        if (roll < clear_pct) begin
            rq.req = REQ_CLEAR;
        end else if (roll < clear_pct + start_pct) begin
            rq.req = REQ_START;
        end else if (roll < clear_pct + start_pct + 38) begin
            rq.req = REQ_APPEND;
        end else begin
            rq.req = REQ_LOOKUP;
        end
        return rq;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_request(input t_route_req rq);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cur_req = rq;
        s_tvalid <= 1'b1;
        s_tdata <= {rq.src, rq.oif, rq.grp};
        s_tuser <= rq.req;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        requests_sent++;
    endtask

    always @(posedge i_clk) begin
        t_route_result want;
        t_route_result typed_res;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (route_results_due.size() == 0) begin
                    report_mismatch("result with nothing pending", 32'(m_tdata), 32'h0);
                end else begin
                    want = route_results_due.pop_front();
                    if (m_tdata[1:0] !== want.status)
                        report_mismatch("status", 32'(m_tdata[1:0]), 32'(want.status));
                    if (m_tdata[2] !== want.outbound)
                        report_mismatch("outbound", 32'(m_tdata[2]), 32'(want.outbound));
                    if (m_tdata[3] !== want.has_if)
                        report_mismatch("has_if", 32'(m_tdata[3]), 32'(want.has_if));
                    if (m_tdata[11:4] !== want.out_if)
                        report_mismatch("out_if", 32'(m_tdata[11:4]), 32'(want.out_if));
                    if (m_tlast !== want.last)
                        report_mismatch("last", 32'(m_tlast), 32'(want.last));
                    if (m_tdata[15:12] !== 4'h0)
                        report_mismatch("pad bits", 32'(m_tdata[15:12]), 32'h0);
                end
            end
            if (s_tvalid && s_tready) begin
                predict_route_results(cur_req);
                if (cur_req.req == REQ_LOOKUP) lookups_sent++;
                foreach (predicted[k]) begin
                    if (predicted[k].has_if && !predicted[k].outbound) ifs_forwarded++;
                    if (predicted[k].status == STS_FULL) full_refusals++;
                end
                if (cur_req.typed) begin
                    typed_res = '{cur_req.typed_sts, cur_req.typed_outb, 1'b0, 8'h00, 1'b1};
                    route_results_due.insert(route_results_due.size(), typed_res);
                end else begin
                    foreach (predicted[k]) begin
                        route_results_due.insert(route_results_due.size(), predicted[k]);
                    end
                end
            end
            if (i_cfg_we) my_node = i_cfg_wdata;
        end
    end

    initial begin
        int gap;
        m_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("watchdog: no transaction for %0d cycles, %0d results still pending",
                 STALL_LIMIT, route_results_due.size());
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int clear_pct;
        int start_pct;
        logic [15:0] node;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = REQ_CLEAR;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        cur_req = DIRECTED[0];
        group_pool[0] = 32'h0000_0000;
        group_pool[1] = 32'hFFFF_FFFF;
        group_pool[2] = BIER_GROUP;
        for (int g = 3; g < POOL_SIZE; g++) group_pool[g] = $urandom;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED[d]) send_request(DIRECTED[d]);
        s_tvalid <= 1'b0;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    node = 16'hFFFF; clear_pct = 2; start_pct = 22; calm = 1'b0;
                end
                1: begin
                    node = 16'($urandom_range(1, 16'hFFFE)); clear_pct = 0; start_pct = 30;
                    calm = 1'b0;
                end
                2: begin
                    node = 16'h0000; clear_pct = 3; start_pct = 20; calm = 1'b1;
                end
                3: begin
                    node = 16'($urandom); clear_pct = 2; start_pct = 20; calm = 1'b0;
                end
                default: begin
                    node = 16'($urandom); clear_pct = 6; start_pct = 25; calm = 1'b0;
                end
            endcase
            while (route_results_due.size() != 0) @(posedge i_clk);
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_wdata <= node;
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            if (ph == 1) hold_req = 1'b1;
            repeat (ITEMS_PER_PHASE) send_request(random_request(clear_pct, start_pct, node));
            s_tvalid <= 1'b0;
        end

        while (route_results_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests (%0d lookups) over %0d node_id settings.",
                 requests_sent, lookups_sent, N_PHASES + 1);
        $display("Checked %0d results: %0d forwarded interfaces, %0d full refusals, %0d mismatches.",
                 results_seen, ifs_forwarded, full_refusals, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
